/* hw/rtl/radar_uart_frame_deframer_macros.svh */
// Assertion macros for the radar UART frame deframer.
`ifndef RADAR_UART_FRAME_DEFRAMER_MACROS_SVH
`define RADAR_UART_FRAME_DEFRAMER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define RUFD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rufd assertion failed");

// Next-cycle implication, checked out of reset.
`define RUFD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("rufd assertion failed");

`endif

/* hw/rtl/rufd_pkg.sv */
// Types, constants and hunter step functions for the radar UART frame deframer.
`default_nettype none
package rufd_pkg;

    localparam int unsigned MAX_PAYLOAD = 128;
    localparam logic [7:0]  MAX_PAYLOAD_B = 8'(MAX_PAYLOAD);

    localparam logic [7:0] OBJ_MARKER   = 8'h01;
    localparam logic [7:0] STAT_MARKER0 = 8'hF0;
    localparam logic [7:0] STAT_MARKER1 = 8'h1A;

    localparam logic [2:0] HDR_LEN_IDX   = 3'd2;
    localparam logic [2:0] HDR_HIGH_IDX  = 3'd3;
    localparam logic [2:0] HDR_LAST_IDX  = 3'd5;

    localparam logic [1:0] KIND_OBJ  = 2'd0;
    localparam logic [1:0] KIND_STAT = 2'd1;
    localparam logic [1:0] KIND_REQ  = 2'd2;
    localparam logic [1:0] KIND_CLR  = 2'd3;

    localparam logic [2:0] REG_OBJ_LEN    = 3'd0;
    localparam logic [2:0] REG_STAT_LEN   = 3'd1;
    localparam logic [2:0] REG_INTERVAL   = 3'd2;
    localparam logic [2:0] REG_IDLE_REQ   = 3'd3;
    localparam logic [2:0] REG_IDLE_CLR   = 3'd4;

    localparam logic [7:0]  RST_OBJ_LEN  = 8'd128;
    localparam logic [7:0]  RST_STAT_LEN = 8'd32;
    localparam logic [7:0]  RST_INTERVAL = 8'd16;
    localparam logic [13:0] RST_IDLE_REQ = 14'd6002;
    localparam logic [13:0] RST_IDLE_CLR = 14'd1000;

    typedef enum logic [2:0] {
        PH_HUNT    = 3'b001,
        PH_HEADER  = 3'b010,
        PH_PAYLOAD = 3'b100
    } t_phase;

    typedef struct packed {
        t_phase      phase;
        logic        saw;
        logic [2:0]  idx;
        logic        bad;
        logic [7:0]  cnt;
    } t_hunter;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic       last;
    } t_result;

    localparam t_hunter HUNTER_RST = '{phase: PH_HUNT, saw: 1'b0, idx: 3'd0,
                                       bad: 1'b0, cnt: 8'd0};

    function automatic t_hunter f_enter_header(t_hunter h);
        t_hunter r;
        r       = h;
        r.phase = PH_HEADER;
        r.idx   = HDR_LEN_IDX;
        r.bad   = 1'b0;
        r.saw   = 1'b0;
        return r;
    endfunction

    function automatic t_hunter f_header_step(t_hunter h, logic [7:0] c, logic [7:0] len);
        t_hunter r;
        r = h;
        if (h.idx == HDR_LEN_IDX && c != len) begin
            r.bad = 1'b1;
        end
        if (h.idx == HDR_HIGH_IDX && c != 8'd0) begin
            r.bad = 1'b1;
        end
        r.idx = h.idx + 3'd1;
        if (r.idx > HDR_LAST_IDX) begin
            if (!r.bad) begin
                r.phase = PH_PAYLOAD;
                r.cnt   = 8'd0;
            end else begin
                r.phase = PH_HUNT;
            end
            r.saw = 1'b0;
        end
        return r;
    endfunction

    function automatic logic f_payload_end(t_hunter h, logic [7:0] len);
        logic [7:0] eff;
        logic [8:0] cnt;
        eff = (len > MAX_PAYLOAD_B) ? MAX_PAYLOAD_B : len;
        cnt = {1'b0, h.cnt} + 9'd1;
        return cnt >= {1'b0, eff};
    endfunction

    function automatic t_hunter f_payload_step(t_hunter h, logic [7:0] len);
        t_hunter r;
        r = h;
        if (f_payload_end(h, len)) begin
            r.phase = PH_HUNT;
            r.saw   = 1'b0;
            r.cnt   = 8'd0;
        end else begin
            r.cnt = h.cnt + 8'd1;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/radar_uart_frame_deframer.sv */
// A taken beat is registered, then its results load into the result buffer at the output.
// Throughput: one input beat per cycle when it yields at most one result and the output is
// ready; a beat with k results (up to three per beat) holds the three-entry result buffer.
// Reset: synchronous active-low i_rst_n; hunters return to hunting, counters clear,
// registers take their defaults, both buffers empty.
// Top level of the radar UART frame deframer.
`default_nettype none
`include "radar_uart_frame_deframer_macros.svh"
module radar_uart_frame_deframer (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_in_valid,
    output logic                         o_in_ready,
    input  wire logic                    i_mode,
    input  wire logic [7:0]              i_rx_byte,
    output logic                         o_out_valid,
    input  wire logic                    i_out_ready,
    output logic [1:0]                   o_kind,
    output logic [7:0]                   o_data,
    output logic                         o_last,
    input  wire logic                    i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire logic [2:0]              i_cfg_index,
    input  wire logic [13:0]             i_cfg_data
);
    import rufd_pkg::*;

    logic        r_in_valid;
    logic        r_mode;
    logic [7:0]  r_byte;

    logic [7:0]  r_obj_len;
    logic [7:0]  r_stat_len;
    logic [7:0]  r_interval;
    logic [13:0] r_idle_req;
    logic [13:0] r_idle_clr;

    t_hunter     r_obj, n_obj;
    t_hunter     r_stat, n_stat;
    logic [7:0]  r_frame, n_frame;
    logic [13:0] r_idle, n_idle;

    t_result     r_res [3];
    t_result     n_res [3];
    logic [1:0]  r_cnt, n_cnt;

    t_result     w_cand [4];
    logic [3:0]  w_cvld;
    t_result     w_res [3];
    logic [1:0]  w_res_n;
    logic        w_load;
    logic        w_pop;
    logic        w_obj_end;
    logic [14:0] w_idle_next;
    logic [8:0]  w_frame_next;

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = (r_cnt != 2'd0);
    assign o_kind      = r_res[0].kind;
    assign o_data      = r_res[0].data;
    assign o_last      = r_res[0].last;

    assign w_pop  = o_out_valid && i_out_ready;
    assign w_load = r_in_valid && (r_cnt == 2'd0 || (r_cnt == 2'd1 && w_pop));
    assign o_in_ready = !r_in_valid || w_load;

    assign w_idle_next  = {1'b0, r_idle} + 15'd1;
    assign w_frame_next = {1'b0, r_frame} + 9'd1;

    always_comb begin
        n_obj     = r_obj;
        n_stat    = r_stat;
        n_frame   = r_frame;
        n_idle    = r_idle;
        w_cvld    = 4'b0000;
        w_obj_end = 1'b0;
        w_cand[0] = '{kind: KIND_OBJ,  data: r_byte, last: 1'b0};
        w_cand[1] = '{kind: KIND_REQ,  data: 8'd0,   last: 1'b0};
        w_cand[2] = '{kind: KIND_STAT, data: r_byte, last: 1'b0};
        w_cand[3] = '{kind: KIND_CLR,  data: 8'd0,   last: 1'b0};
        if (r_mode) begin
            if (w_idle_next >= {1'b0, r_idle_req}) begin
                w_cvld[1] = 1'b1;
                n_idle    = 14'd0;
            end else begin
                n_idle = w_idle_next[13:0];
            end
            w_cvld[3] = (n_idle == r_idle_clr);
        end else begin
            unique case (r_obj.phase)
                PH_PAYLOAD: begin
                    w_obj_end      = f_payload_end(r_obj, r_obj_len);
                    n_obj          = f_payload_step(r_obj, r_obj_len);
                    n_idle         = 14'd0;
                    w_cvld[0]      = 1'b1;
                    w_cand[0].last = w_obj_end;
                    if (w_obj_end) begin
                        if (w_frame_next >= {1'b0, r_interval}) begin
                            w_cvld[1] = 1'b1;
                            n_frame   = 8'd0;
                        end else begin
                            n_frame = w_frame_next[7:0];
                        end
                    end
                end
                PH_HEADER: begin
                    n_obj = f_header_step(r_obj, r_byte, r_obj_len);
                end
                default: begin
                    if (r_byte == OBJ_MARKER) begin
                        if (r_obj.saw) begin
                            n_obj = f_enter_header(r_obj);
                        end else begin
                            n_obj.saw = 1'b1;
                        end
                    end else begin
                        n_obj.saw = 1'b0;
                    end
                end
            endcase
            unique case (r_stat.phase)
                PH_PAYLOAD: begin
                    w_cvld[2]      = 1'b1;
                    w_cand[2].last = f_payload_end(r_stat, r_stat_len);
                    n_stat         = f_payload_step(r_stat, r_stat_len);
                end
                PH_HEADER: begin
                    n_stat = f_header_step(r_stat, r_byte, r_stat_len);
                end
                default: begin
                    if (r_byte == STAT_MARKER0) begin
                        n_stat.saw = 1'b1;
                    end else if (r_byte == STAT_MARKER1 && r_stat.saw) begin
                        n_stat = f_enter_header(r_stat);
                    end else begin
                        n_stat.saw = 1'b0;
                    end
                end
            endcase
        end
    end

    // pack valid candidates in order: object, request, status, clear
    always_comb begin
        w_res[0] = w_cand[0];
        w_res[1] = w_cand[1];
        w_res[2] = w_cand[2];
        w_res_n  = 2'd0;
        for (int j = 0; j < 4; j++) begin
            if (w_cvld[j] && w_res_n != 2'd3) begin
                w_res[w_res_n] = w_cand[j];
                w_res_n        = w_res_n + 2'd1;
            end
        end
    end

    always_comb begin
        n_res = r_res;
        n_cnt = r_cnt;
        if (w_pop) begin
            n_res[0] = r_res[1];
            n_res[1] = r_res[2];
            n_cnt    = r_cnt - 2'd1;
        end
        if (w_load) begin
            n_res = w_res;
            n_cnt = w_res_n;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_cnt      <= 2'd0;
            r_obj      <= HUNTER_RST;
            r_stat     <= HUNTER_RST;
            r_frame    <= 8'd0;
            r_idle     <= 14'd0;
            r_obj_len  <= RST_OBJ_LEN;
            r_stat_len <= RST_STAT_LEN;
            r_interval <= RST_INTERVAL;
            r_idle_req <= RST_IDLE_REQ;
            r_idle_clr <= RST_IDLE_CLR;
        end else begin
            r_cnt <= n_cnt;
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_load) begin
                r_obj   <= n_obj;
                r_stat  <= n_stat;
                r_frame <= n_frame;
                r_idle  <= n_idle;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    REG_OBJ_LEN:  r_obj_len  <= i_cfg_data[7:0];
                    REG_STAT_LEN: r_stat_len <= i_cfg_data[7:0];
                    REG_INTERVAL: r_interval <= i_cfg_data[7:0];
                    REG_IDLE_REQ: r_idle_req <= i_cfg_data;
                    REG_IDLE_CLR: r_idle_clr <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_mode <= i_mode;
            r_byte <= i_rx_byte;
        end
        r_res <= n_res;
    end

    `RUFD_ASSERT_IMP(a_ctrl_kind_clean, i_clk, i_rst_n,
        o_out_valid && (o_kind == KIND_REQ || o_kind == KIND_CLR),
        o_data == 8'd0 && !o_last)
    `RUFD_ASSERT_IMP(a_no_load_when_busy, i_clk, i_rst_n, r_cnt > 2'd1, !w_load)
    `RUFD_ASSERT_NXT(a_load_count, i_clk, i_rst_n, w_load, r_cnt == $past(w_res_n))

endmodule
`default_nettype wire

/* sim/tb_radar_uart_frame_deframer.sv */
// Testbench for the radar UART frame deframer: directed and random beats checked in order.
`timescale 1ns / 1ps

module tb_radar_uart_frame_deframer;
    import rufd_pkg::*;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 12;

    localparam logic [7:0] OPENING [24] = '{
        8'h01, 8'h01, 8'h02, 8'h00, 8'hFF, 8'h00, 8'h00, 8'hFF,
        8'hF0, 8'h1A, 8'h01, 8'h00, 8'h55, 8'hAA, 8'h80,
        8'h01, 8'h01, 8'h07, 8'hF0, 8'h1A, 8'h01, 8'h05, 8'h00, 8'h00
    };

    typedef struct packed {
        logic       mode;
        logic [7:0] value;
    } t_rx_item;

    typedef struct {
        t_phase     phase;
        bit         saw;
        logic [2:0] pos;
        bit         bad;
        logic [7:0] count;
    } t_hunt_state;

    class deframe_scoreboard;
        logic [7:0]  obj_len;
        logic [7:0]  stat_len;
        logic [7:0]  period;
        logic [13:0] idle_req;
        logic [13:0] idle_clr;
        t_hunt_state obj_h;
        t_hunt_state stat_h;
        logic [7:0]  frames;
        logic [13:0] idle_ticks;
        t_result     due[$];
        int          errors;

        function new();
            obj_len    = RST_OBJ_LEN;
            stat_len   = RST_STAT_LEN;
            period     = RST_INTERVAL;
            idle_req   = RST_IDLE_REQ;
            idle_clr   = RST_IDLE_CLR;
            obj_h      = '{phase: PH_HUNT, saw: 1'b0, pos: 3'd0, bad: 1'b0, count: 8'd0};
            stat_h     = obj_h;
            frames     = 8'd0;
            idle_ticks = 14'd0;
            errors     = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [13:0] val);
            case (idx)
                REG_OBJ_LEN:  obj_len  = val[7:0];
                REG_STAT_LEN: stat_len = val[7:0];
                REG_INTERVAL: period   = val[7:0];
                REG_IDLE_REQ: idle_req = val;
                REG_IDLE_CLR: idle_clr = val;
                default: ;
            endcase
        endfunction

        function void queue_result(logic [1:0] kind, logic [7:0] data, logic last);
            t_result r;
            r.kind = kind;
            r.data = data;
            r.last = last;
            due.push_back(r);
        endfunction

        function t_hunt_state start_header(t_hunt_state h);
            h.phase = PH_HEADER;
            h.pos   = HDR_LEN_IDX;
            h.bad   = 1'b0;
            h.saw   = 1'b0;
            return h;
        endfunction

        function t_hunt_state header_step(t_hunt_state h, logic [7:0] c, logic [7:0] len);
            if (h.pos == HDR_LEN_IDX && c != len) h.bad = 1'b1;
            if (h.pos == HDR_HIGH_IDX && c != 8'h00) h.bad = 1'b1;
            h.pos = h.pos + 3'd1;
            if (h.pos > HDR_LAST_IDX) begin
                h.phase = h.bad ? PH_HUNT : PH_PAYLOAD;
                h.count = 8'd0;
                h.saw   = 1'b0;
            end
            return h;
        endfunction

        function bit payload_done(t_hunt_state h, logic [7:0] len);
            int lim;
            lim = (int'(len) > MAX_PAYLOAD) ? MAX_PAYLOAD : int'(len);
            return int'(h.count) + 1 >= lim;
        endfunction

        function t_hunt_state payload_step(t_hunt_state h, bit done);
            if (done) begin
                h.phase = PH_HUNT;
                h.saw   = 1'b0;
                h.count = 8'd0;
            end else begin
                h.count = h.count + 8'd1;
            end
            return h;
        endfunction

        function void note_beat(logic mode, logic [7:0] c);
            bit done;
            if (mode) begin
                if (int'(idle_ticks) + 1 >= int'(idle_req)) begin
                    queue_result(KIND_REQ, 8'h00, 1'b0);
                    idle_ticks = 14'd0;
                end else begin
                    idle_ticks = idle_ticks + 14'd1;
                end
                if (idle_ticks == idle_clr) queue_result(KIND_CLR, 8'h00, 1'b0);
            end else begin
                case (obj_h.phase)
                    PH_PAYLOAD: begin
                        done       = payload_done(obj_h, obj_len);
                        obj_h      = payload_step(obj_h, done);
                        idle_ticks = 14'd0;
                        queue_result(KIND_OBJ, c, done);
                        if (done) begin
                            if (int'(frames) + 1 >= int'(period)) begin
                                queue_result(KIND_REQ, 8'h00, 1'b0);
                                frames = 8'd0;
                            end else begin
                                frames = frames + 8'd1;
                            end
                        end
                    end
                    PH_HEADER: obj_h = header_step(obj_h, c, obj_len);
                    default: begin
                        if (c == OBJ_MARKER) begin
                            if (obj_h.saw) obj_h = start_header(obj_h);
                            else obj_h.saw = 1'b1;
                        end else begin
                            obj_h.saw = 1'b0;
                        end
                    end
                endcase
                case (stat_h.phase)
                    PH_PAYLOAD: begin
                        done   = payload_done(stat_h, stat_len);
                        stat_h = payload_step(stat_h, done);
                        queue_result(KIND_STAT, c, done);
                    end
                    PH_HEADER: stat_h = header_step(stat_h, c, stat_len);
                    default: begin
                        if (c == STAT_MARKER0) stat_h.saw = 1'b1;
                        else if (c == STAT_MARKER1 && stat_h.saw) stat_h = start_header(stat_h);
                        else stat_h.saw = 1'b0;
                    end
                endcase
            end
        endfunction

        function void check_result(logic [1:0] kind, logic [7:0] data, logic last);
            t_result want;
            if (due.size() == 0) begin
                $display("%0t: unexpected result kind %0d data %02h last %0d",
                         $time, kind, data, last);
                errors++;
            end else begin
                want = due.pop_front();
                if (want.kind !== kind) begin
                    $display("%0t: kind expected %0d actual %0d", $time, want.kind, kind);
                    errors++;
                end
                if (want.data !== data) begin
                    $display("%0t: data expected %02h actual %02h", $time, want.data, data);
                    errors++;
                end
                if (want.last !== last) begin
                    $display("%0t: last expected %0d actual %0d", $time, want.last, last);
                    errors++;
                end
            end
        endfunction
    endclass

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        i_mode      = 1'b0;
    logic [7:0]  i_rx_byte   = 8'h00;
    logic        i_out_ready = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [2:0]  i_cfg_index = 3'd0;
    logic [13:0] i_cfg_data  = 14'd0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [1:0]  o_kind;
    logic [7:0]  o_data;
    logic        o_last;
    logic        o_cfg_ready;

    deframe_scoreboard sb;
    t_rx_item          feed[$];
    bit                quiet = 1'b0;
    int                out_stall = 0;

    radar_uart_frame_deframer u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_mode      (i_mode),
        .i_rx_byte   (i_rx_byte),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_kind      (o_kind),
        .o_data      (o_data),
        .o_last      (o_last),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic int payload_bytes(logic [7:0] len);
        if (len == 8'd0) return 1;
        return (int'(len) > MAX_PAYLOAD) ? MAX_PAYLOAD : int'(len);
    endfunction

    function automatic void queue_byte(logic [7:0] v);
        t_rx_item it;
        it.mode  = 1'b0;
        it.value = v;
        feed.push_back(it);
    endfunction

    function automatic void queue_tick();
        t_rx_item it;
        it.mode  = 1'b1;
        it.value = 8'($urandom_range(0, 255));
        feed.push_back(it);
    endfunction

    function automatic logic [7:0] noise_byte();
        case ($urandom_range(0, 5))
            0: return 8'h00;
            1: return 8'hFF;
            2: return OBJ_MARKER;
            3: return STAT_MARKER0;
            4: return STAT_MARKER1;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic void queue_frame(bit is_stat, logic [7:0] len);
        int flaw;
        flaw = ($urandom_range(0, 9) < 8) ? 0 : $urandom_range(1, 3);
        queue_byte(is_stat ? STAT_MARKER0 : OBJ_MARKER);
        queue_byte(is_stat ? STAT_MARKER1 : OBJ_MARKER);
        if (flaw == 3) return;
        queue_byte(flaw == 1 ? len ^ 8'($urandom_range(1, 255)) : len);
        queue_byte(flaw == 2 ? 8'($urandom_range(1, 255)) : 8'h00);
        queue_byte(8'($urandom_range(0, 255)));
        queue_byte(8'($urandom_range(0, 255)));
        if (flaw == 0) repeat (payload_bytes(len)) queue_byte(8'($urandom_range(0, 255)));
    endfunction

    function automatic void queue_nested(int body);
        queue_byte(OBJ_MARKER);
        queue_byte(OBJ_MARKER);
        queue_byte(sb.obj_len);
        queue_byte(8'h00);
        queue_byte(8'($urandom_range(0, 255)));
        queue_byte(8'($urandom_range(0, 255)));
        queue_byte(STAT_MARKER0);
        queue_byte(STAT_MARKER1);
        queue_byte(sb.stat_len);
        queue_byte(8'h00);
        queue_byte(8'($urandom_range(0, 255)));
        queue_byte(8'($urandom_range(0, 255)));
        repeat (body) queue_byte(8'($urandom_range(0, 255)));
    endfunction

    function automatic void queue_random_seq();
        int pick;
        int body;
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            queue_frame(1'b0, sb.obj_len);
        end else if (pick < 50) begin
            queue_frame(1'b1, sb.stat_len);
        end else if (pick < 62) begin
            body = payload_bytes(sb.obj_len) - 6;
            if (body < payload_bytes(sb.stat_len)) body = payload_bytes(sb.stat_len);
            queue_nested(body);
        end else if (pick < 80) begin
            repeat ($urandom_range(1, 12)) queue_tick();
        end else begin
            repeat ($urandom_range(1, 6)) queue_byte(noise_byte());
        end
    endfunction

    task automatic send_beat(input t_rx_item it);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_mode     <= it.mode;
        i_rx_byte  <= it.value;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_beat(it.mode, it.value);
    endtask

    task automatic play_feed();
        foreach (feed[i]) send_beat(feed[i]);
        feed.delete();
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [13:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.set_reg(idx, val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_config(input logic [7:0] obj_len, input logic [7:0] stat_len,
                              input logic [7:0] period, input logic [13:0] req_ticks,
                              input logic [13:0] clr_ticks);
        write_reg(REG_OBJ_LEN, 14'(obj_len));
        write_reg(REG_STAT_LEN, 14'(stat_len));
        write_reg(REG_INTERVAL, 14'(period));
        write_reg(REG_IDLE_REQ, req_ticks);
        write_reg(REG_IDLE_CLR, clr_ticks);
    endtask

    task automatic run_random(input int budget);
        while (feed.size() < budget) queue_random_seq();
        play_feed();
        drain();
    endtask

    initial begin
        forever begin
            @(negedge i_clk);
            if (out_stall > 0) begin
                i_out_ready <= 1'b0;
                out_stall--;
            end else begin
                i_out_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0) out_stall = pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_result(o_kind, o_data, o_last);
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("tb_radar_uart_frame_deframer NOT OK");
        $finish;
    end

    initial begin
        sb = new();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        set_config(8'd2, 8'd1, 8'd1, 14'd3, 14'd2);
        foreach (OPENING[i]) queue_byte(OPENING[i]);
        repeat (3) queue_tick();
        play_feed();
        drain();

        quiet = 1'b1;
        set_config(8'd1, 8'd1, 8'd1, 14'd1, 14'd1);
        run_random(5);

        quiet = 1'b0;
        set_config(8'd4, 8'd3, 8'd2, 14'd5, 14'd3);
        run_random(5);

        set_config(8'd0, 8'd0, 8'd0, 14'd0, 14'd0);
        run_random(4);

        quiet = 1'b1;
        set_config(8'd9, 8'd4, 8'd1, 14'd4, 14'd2);
        run_random(5);

        // cap the object frame, hold the status frame and counters mid-count, then lower
        quiet = 1'b0;
        set_config(8'd200, 8'd128, 8'd255, 14'd16383, 14'd16383);
        queue_nested(122);
        repeat (2) queue_tick();
        play_feed();
        drain();

        set_config(8'd2, 8'd4, 8'd1, 14'd2, 14'd1);
        queue_tick();
        queue_frame(1'b0, sb.obj_len);
        play_feed();
        drain();

        set_config(8'd1, 8'd2, 8'd3, 14'd7, 14'd5);
        run_random(5);

        if (sb.errors == 0) begin
            $display("tb_radar_uart_frame_deframer OK");
        end else begin
            $display("tb_radar_uart_frame_deframer NOT OK");
        end
        $finish;
    end
endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/rufd_pkg.sv
hw/rtl/radar_uart_frame_deframer.sv
sim/tb_radar_uart_frame_deframer.sv
